// ===== design/htt_pkg.sv =====
// ----------------------------------------------------------------------------
// htt_pkg
// Shared types, byte constants and the byte classifier for the tag tokenizer.
// ----------------------------------------------------------------------------
package htt_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_TEXT  = 4'd1,
    M_LT    = 4'd2,
    M_CLOSE = 4'd3,
    M_OPEN  = 4'd4,
    M_ATTRS = 4'd5,
    M_KEY   = 4'd6,
    M_EQ    = 4'd7,
    M_VALUE = 4'd8,
    M_UNQ   = 4'd9,
    M_SLASH = 4'd10
  } mode_t;

  typedef enum logic [2:0] {
    R_MARKUP = 3'd0,
    R_TEXT   = 3'd1,
    R_OPEN   = 3'd2,
    R_CLOSE  = 3'd3,
    R_KEY    = 3'd4,
    R_VALUE  = 3'd5
  } role_t;

  typedef enum logic [1:0] {
    T_NONE  = 2'd0,
    T_OPEN  = 2'd1,
    T_SELF  = 2'd2,
    T_CLOSE = 2'd3
  } tag_t;

  typedef enum logic [2:0] {
    C_OTHER = 3'd0,
    C_LT    = 3'd1,
    C_SLASH = 3'd2,
    C_GT    = 3'd3,
    C_EQ    = 3'd4,
    C_SP    = 3'd5,
    C_QUOTE = 3'd6
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    cls_t       cls;
  } qitem_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           full;
    logic           empty;
  } qstat_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    case (c)
      CH_LT:    k = C_LT;
      CH_SLASH: k = C_SLASH;
      CH_GT:    k = C_GT;
      CH_EQ:    k = C_EQ;
      CH_SP:    k = C_SP;
      CH_QUOTE: k = C_QUOTE;
      default:  k = C_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ===== design/htt_front.sv =====
// ----------------------------------------------------------------------------
// htt_front
// Input side: takes a byte beat when the queue has room and tags it with its
// character class.
// ----------------------------------------------------------------------------
module htt_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      char_in,
  input  logic            last_byte,
  input  htt_pkg::qstat_t q_stat,
  output logic            push,
  output htt_pkg::qitem_t push_item
);

  assign in_ready       = !q_stat.full;
  assign push           = in_valid && !q_stat.full;
  assign push_item.ch   = char_in;
  assign push_item.last = last_byte;
  assign push_item.cls  = htt_pkg::classify(char_in);

endmodule

// ===== design/htt_fifo.sv =====
// ----------------------------------------------------------------------------
// htt_fifo
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module htt_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  htt_pkg::qitem_t push_item,
  input  logic            pop,
  output htt_pkg::qitem_t pop_item,
  output htt_pkg::qstat_t stat
);

  htt_pkg::qitem_t             mem [htt_pkg::QDEPTH];
  logic [htt_pkg::QAW-1:0]     wr_ptr;
  logic [htt_pkg::QAW-1:0]     rd_ptr;
  logic [htt_pkg::QCW-1:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_item   = mem[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == htt_pkg::QCW'(htt_pkg::QDEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== design/htt_back.sv =====
// ----------------------------------------------------------------------------
// htt_back
// Parse state machine: pops one classified byte per cycle while the output
// register is free, assigns its role and end flags, and registers the result.
// ----------------------------------------------------------------------------
module htt_back (
  input  logic            clk,
  input  logic            rst,
  input  htt_pkg::qstat_t q_stat,
  input  htt_pkg::qitem_t q_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      char_out,
  output logic [2:0]      role,
  output logic            text_done,
  output logic            attr_done,
  output logic [1:0]      tag_done,
  output logic            unterminated
);

  htt_pkg::mode_t mode;
  htt_pkg::mode_t mode_next;
  htt_pkg::mode_t nxt;
  htt_pkg::role_t r_d;
  htt_pkg::tag_t  t_d;
  logic           td_d;
  logic           ad_d;
  logic           ut_d;

  // output register frees up when empty or being drained this cycle
  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= htt_pkg::M_IDLE;
    end else begin
      mode <= mode_next;
    end
  end

  always_comb begin
    nxt  = htt_pkg::M_IDLE;
    r_d  = htt_pkg::R_MARKUP;
    t_d  = htt_pkg::T_NONE;
    td_d = 1'b0;
    ad_d = 1'b0;
    ut_d = 1'b0;
    case (mode)
      htt_pkg::M_LT: begin
        case (q_item.cls)
          htt_pkg::C_SLASH: nxt = htt_pkg::M_CLOSE;
          htt_pkg::C_GT:    t_d = htt_pkg::T_OPEN;
          htt_pkg::C_SP:    nxt = htt_pkg::M_ATTRS;
          default: begin
            r_d = htt_pkg::R_OPEN;
            nxt = htt_pkg::M_OPEN;
          end
        endcase
      end
      htt_pkg::M_CLOSE: begin
        if (q_item.cls == htt_pkg::C_GT) begin
          t_d = htt_pkg::T_CLOSE;
        end else begin
          r_d = htt_pkg::R_CLOSE;
          nxt = htt_pkg::M_CLOSE;
        end
      end
      htt_pkg::M_OPEN: begin
        case (q_item.cls)
          htt_pkg::C_GT:    t_d = htt_pkg::T_OPEN;
          htt_pkg::C_SLASH: nxt = htt_pkg::M_SLASH;
          htt_pkg::C_SP:    nxt = htt_pkg::M_ATTRS;
          default: begin
            r_d = htt_pkg::R_OPEN;
            nxt = htt_pkg::M_OPEN;
          end
        endcase
      end
      htt_pkg::M_ATTRS: begin
        case (q_item.cls)
          htt_pkg::C_SP:    nxt = htt_pkg::M_ATTRS;
          htt_pkg::C_GT:    t_d = htt_pkg::T_OPEN;
          htt_pkg::C_SLASH: nxt = htt_pkg::M_SLASH;
          default: begin
            r_d = htt_pkg::R_KEY;
            nxt = htt_pkg::M_KEY;
          end
        endcase
      end
      htt_pkg::M_KEY: begin
        case (q_item.cls)
          htt_pkg::C_EQ: nxt = htt_pkg::M_EQ;
          htt_pkg::C_GT: t_d = htt_pkg::T_OPEN;
          default: begin
            r_d = htt_pkg::R_KEY;
            nxt = htt_pkg::M_KEY;
          end
        endcase
      end
      htt_pkg::M_EQ: begin
        case (q_item.cls)
          htt_pkg::C_SP:    nxt = htt_pkg::M_EQ;
          htt_pkg::C_QUOTE: nxt = htt_pkg::M_VALUE;
          htt_pkg::C_GT:    t_d = htt_pkg::T_OPEN;
          default:          nxt = htt_pkg::M_UNQ;
        endcase
      end
      htt_pkg::M_VALUE: begin
        if (q_item.cls == htt_pkg::C_QUOTE) begin
          ad_d = 1'b1;
          nxt  = htt_pkg::M_ATTRS;
        end else begin
          r_d = htt_pkg::R_VALUE;
          nxt = htt_pkg::M_VALUE;
        end
      end
      htt_pkg::M_UNQ: begin
        case (q_item.cls)
          htt_pkg::C_SP: nxt = htt_pkg::M_ATTRS;
          htt_pkg::C_GT: t_d = htt_pkg::T_OPEN;
          default:       nxt = htt_pkg::M_UNQ;
        endcase
      end
      // self-closing end takes whatever byte follows the slash
      htt_pkg::M_SLASH: t_d = htt_pkg::T_SELF;
      default: begin
        if (q_item.cls == htt_pkg::C_LT) begin
          td_d = (mode == htt_pkg::M_TEXT);
          nxt  = htt_pkg::M_LT;
        end else begin
          r_d = htt_pkg::R_TEXT;
          nxt = htt_pkg::M_TEXT;
        end
      end
    endcase

    // end of document closes a text run or flags an open tag
    if (q_item.last) begin
      if (nxt == htt_pkg::M_TEXT) begin
        td_d = 1'b1;
      end else if (nxt != htt_pkg::M_IDLE) begin
        ut_d = 1'b1;
      end
      nxt = htt_pkg::M_IDLE;
    end

    mode_next = pop ? nxt : mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pop || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_out     <= q_item.ch;
      role         <= r_d;
      text_done    <= td_d;
      attr_done    <= ad_d;
      tag_done     <= t_d;
      unterminated <= ut_d;
    end
  end

endmodule

// ===== design/html_tag_tokenizer.sv =====
// ----------------------------------------------------------------------------
// html_tag_tokenizer
// Classifies markup bytes into text, tag names, attribute keys and values,
// with flags for the ends of text runs, attributes and tags.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid / in_ready   char_in, last_byte
//  output   out_valid / out_ready char_out, role, text_done, attr_done,
//                                 tag_done, unterminated
//
//  one byte per clock sustained while out_ready is held high; a byte taken
//  is written into the queue and then into the output register, and an
//  output stall can hold it in the queue.
//  a four-entry queue between classifier and parse machine absorbs output
//  stalls; in_ready drops only when the queue is full.
//  synchronous reset empties the queue, drops out_valid and returns the
//  parse machine to idle.
// ----------------------------------------------------------------------------
module html_tag_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out,
  output logic [2:0] role,
  output logic       text_done,
  output logic       attr_done,
  output logic [1:0] tag_done,
  output logic       unterminated
);

  htt_pkg::qstat_t q_stat;
  htt_pkg::qitem_t push_item;
  htt_pkg::qitem_t pop_item;
  logic            push;
  logic            pop;

  htt_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_in   (char_in),
    .last_byte (last_byte),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  htt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  htt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_item       (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_out     (char_out),
    .role         (role),
    .text_done    (text_done),
    .attr_done    (attr_done),
    .tag_done     (tag_done),
    .unterminated (unterminated)
  );

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= htt_pkg::QCW'(htt_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_q_flow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count missed a beat");

  a_tag_markup: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tag_done != htt_pkg::T_NONE) |->
      (role == htt_pkg::R_MARKUP && unterminated == 1'b0))
    else $error("tag end on a non-markup or unterminated beat");

  a_attr_quote: assert property (@(posedge clk) disable iff (rst)
    (out_valid && attr_done) |->
      (char_out == htt_pkg::CH_QUOTE && role == htt_pkg::R_MARKUP))
    else $error("attribute end away from a closing quote");
`endif

endmodule
